>>> hdl/rfcomm_frame_header_fcs_builder_defines.svh
// Assertion macros shared by the frame header and FCS builder RTL.
`ifndef RFCOMM_FRAME_HEADER_FCS_BUILDER_DEFINES_SVH
`define RFCOMM_FRAME_HEADER_FCS_BUILDER_DEFINES_SVH

// Same-cycle implication, clocked on clk, disabled during rst.
`define RFCB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, disabled during rst.
`define RFCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/rfcb_pkg.sv
// Package: beat types, control codes and the CRC-8 step for the header builder.
package rfcb_pkg;

  // Frame kind codes
  localparam logic [2:0] KIND_SABM = 3'd0;
  localparam logic [2:0] KIND_UA   = 3'd1;
  localparam logic [2:0] KIND_DM   = 3'd2;
  localparam logic [2:0] KIND_DISC = 3'd3;
  localparam logic [2:0] KIND_UIH  = 3'd4;

  // Control byte codes
  localparam logic [7:0] CODE_SABM  = 8'h2F;
  localparam logic [7:0] CODE_UA    = 8'h63;
  localparam logic [7:0] CODE_DM    = 8'h0F;
  localparam logic [7:0] CODE_DISC  = 8'h43;
  localparam logic [7:0] CODE_UIH   = 8'hEF;
  localparam logic [7:0] POLL_FINAL = 8'h10;

  // CRC-8 (x^8+x^2+x+1), LSB first
  localparam logic [7:0] FCS_INIT      = 8'hFF;
  localparam logic [7:0] CRC_POLY_REFL = 8'hE0;

  // Length field byte counts
  localparam logic [1:0] LEN_ONE_BYTE = 2'd1;
  localparam logic [1:0] LEN_TWO_BYTE = 2'd2;

  typedef struct packed {
    logic [2:0]  frame_kind;
    logic [5:0]  dlci;
    logic [14:0] payload_length;
    logic        locally_initiated;
  } req_t;

  typedef struct packed {
    logic [7:0] address_byte;
    logic [7:0] control_byte;
    logic [7:0] length_first;
    logic [7:0] length_second;
    logic [1:0] length_bytes;
    logic [7:0] fcs;
  } hdr_t;

  // One byte of the reflected CRC-8
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> hdl/rfcomm_frame_header_fcs_builder.sv
// Top level: four-stage pipeline that builds an RFCOMM frame header and its FCS.
//
// Usage:
//   Input channel (in_valid / in_ready / in_data) carries one frame request per
//   beat: frame kind, DLCI, payload length and the local-initiator flag.
//   Output channel (out_valid / out_ready / out_data) carries one header beat per
//   request: address, control, one or two length bytes, byte count and FCS.
//   Kinds 5..7 are built exactly like UIH.
// Timing:
//   Four register stages: field build, CRC over address and control, CRC over
//   the first length byte, CRC over the second length byte plus inversion.
//   out_valid rises once a request has passed stages 1 to 4. Unless the pipe
//   is full and stalled, a new request is taken every cycle; throughput is one
//   beat per cycle, set by the single-pass chain, one byte-wide CRC step group each.
// Reset:
//   rst (synchronous, active high) clears all stage valid bits; the pipe is
//   empty and in_ready is high after reset.
// Stall:
//   When out_ready is low the output beat holds; earlier stages keep filling
//   bubbles, and in_ready drops only once every stage holds a beat.
module rfcomm_frame_header_fcs_builder (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rfcb_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rfcb_pkg::hdr_t out_data
);
  import rfcb_pkg::*;

  `include "rfcomm_frame_header_fcs_builder_defines.svh"

  // Stage valid bits
  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;

  // Stage 1 payload
  logic [7:0] addr1, ctrl1, l0_1, l1_1;
  logic       two1, uih1;
  // Stage 2 payload
  logic [7:0] addr2, ctrl2, l0_2, l1_2, crc2;
  logic       two2, uih2;
  // Stage 3 payload
  logic [7:0] addr3, ctrl3, l0_3, l1_3, crc3;
  logic       two3, uih3;
  // Stage 4 (output) payload
  hdr_t       hdr4;

  // Header field build, combinational ahead of stage 1
  logic [7:0] addr_next, ctrl_next, l0_next, l1_next;
  logic       two_next, uih_next, cr;

  // Stall chain: a stage loads when it is empty or its beat moves on
  assign adv4     = !v4 || out_ready;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  // Address, control and length fields
  always_comb begin
    cr       = in_data.locally_initiated;
    uih_next = 1'b0;
    case (in_data.frame_kind)
      KIND_SABM: ctrl_next = CODE_SABM | POLL_FINAL;
      KIND_UA: begin
        ctrl_next = CODE_UA | POLL_FINAL;
        cr        = ~in_data.locally_initiated;
      end
      KIND_DM: begin
        ctrl_next = CODE_DM | POLL_FINAL;
        cr        = ~in_data.locally_initiated;
      end
      KIND_DISC: ctrl_next = CODE_DISC | POLL_FINAL;
      default: begin
        ctrl_next = CODE_UIH;
        uih_next  = 1'b1;
      end
    endcase
    addr_next = {in_data.dlci, cr, 1'b1};
    two_next  = |in_data.payload_length[14:7];
    l0_next   = {in_data.payload_length[6:0], ~two_next};
    l1_next   = two_next ? in_data.payload_length[14:7] : 8'h00;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  // Stage 1: header fields
  always_ff @(posedge clk) begin
    if (adv1) begin
      addr1 <= addr_next;
      ctrl1 <= ctrl_next;
      l0_1  <= l0_next;
      l1_1  <= l1_next;
      two1  <= two_next;
      uih1  <= uih_next;
    end
  end

  // Stage 2: CRC over address and control
  always_ff @(posedge clk) begin
    if (adv2) begin
      addr2 <= addr1;
      ctrl2 <= ctrl1;
      l0_2  <= l0_1;
      l1_2  <= l1_1;
      two2  <= two1;
      uih2  <= uih1;
      crc2  <= crc8_byte(crc8_byte(FCS_INIT, addr1), ctrl1);
    end
  end

  // Stage 3: CRC over first length byte, skipped for UIH
  always_ff @(posedge clk) begin
    if (adv3) begin
      addr3 <= addr2;
      ctrl3 <= ctrl2;
      l0_3  <= l0_2;
      l1_3  <= l1_2;
      two3  <= two2;
      uih3  <= uih2;
      crc3  <= uih2 ? crc2 : crc8_byte(crc2, l0_2);
    end
  end

  // Stage 4: CRC over second length byte when present and not UIH, then invert
  always_ff @(posedge clk) begin
    if (adv4) begin
      hdr4.address_byte  <= addr3;
      hdr4.control_byte  <= ctrl3;
      hdr4.length_first  <= l0_3;
      hdr4.length_second <= l1_3;
      hdr4.length_bytes  <= two3 ? LEN_TWO_BYTE : LEN_ONE_BYTE;
      hdr4.fcs           <= ~((!uih3 && two3) ? crc8_byte(crc3, l1_3) : crc3);
    end
  end

  assign out_valid = v4;
  assign out_data  = hdr4;

  // Checks
  `RFCB_ASSERT_NOW(a_len_short, out_valid && (out_data.length_bytes == LEN_ONE_BYTE), out_data.length_first[0] && (out_data.length_second == 8'h00), "one-byte length with bad extension or second byte")
  `RFCB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output beat dropped while stalled")
  `RFCB_ASSERT_NEXT(a_in_enter, in_valid && in_ready, v1, "accepted request did not enter stage 1")
  `RFCB_ASSERT_NOW(a_full_stall, !in_ready, v1 && v2 && v3 && v4 && !out_ready, "input stalled with a bubble in the pipe")

endmodule

>>> tb/tb_rfcomm_frame_header_fcs_builder.sv
// Self-checking testbench for the RFCOMM frame header and FCS builder.
module tb_rfcomm_frame_header_fcs_builder;
  timeunit 1ns;
  timeprecision 1ps;

  import rfcb_pkg::*;

  localparam int          CLK_PERIOD      = 12;
  localparam int          RESET_CYCLES    = 4;
  localparam logic [14:0] SHORT_LEN_LIMIT = 15'd128;
  localparam int          RANDOM_PER_MODE = 280;
  localparam int          LONG_STALL      = 48;
  localparam int          QUIET_LIMIT     = 1000;
  localparam int          DRAIN_CYCLES    = 10;
  localparam int          PRINT_CAP       = 40;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  req_t   in_data = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  hdr_t   out_data;

  req_t   req_backlog[$];
  hdr_t   hdr_expected[$];

  int     sender_idle_pct = 0;
  int     receiver_idle_pct = 0;
  logic   pressure_armed = 1'b0;
  logic   stall_done = 1'b0;
  int     stall_left = 0;
  int     quiet_cycles = 0;

  int     mismatch_count = 0;
  int     hdr_checked = 0;
  int     two_byte_frames = 0;
  int     uih_like_frames = 0;

  rfcomm_frame_header_fcs_builder i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // One bit-serial step per data bit, LSB first
  function automatic logic [7:0] fcs_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] acc;
    logic       fb;
    acc = crc;
    for (int b = 0; b < 8; b++) begin
      fb  = acc[0] ^ data[b];
      acc = acc >> 1;
      if (fb) acc = acc ^ CRC_POLY_REFL;
    end
    return acc;
  endfunction

  // Expected header for one frame request
  function automatic hdr_t build_header(input req_t r);
    hdr_t       h;
    logic       cr;
    logic       is_uih;
    logic [7:0] crc;
    cr     = r.locally_initiated;
    is_uih = 1'b0;
    case (r.frame_kind)
      KIND_SABM: h.control_byte = CODE_SABM | POLL_FINAL;
      KIND_UA: begin
        h.control_byte = CODE_UA | POLL_FINAL;
        cr = ~cr;
      end
      KIND_DM: begin
        h.control_byte = CODE_DM | POLL_FINAL;
        cr = ~cr;
      end
      KIND_DISC: h.control_byte = CODE_DISC | POLL_FINAL;
      // UIH and the undefined kinds share one encoding
      default: begin
        h.control_byte = CODE_UIH;
        is_uih = 1'b1;
      end
    endcase
    h.address_byte = {r.dlci, cr, 1'b1};
    if (r.payload_length < SHORT_LEN_LIMIT) begin
      h.length_first  = {r.payload_length[6:0], 1'b1};
      h.length_second = 8'h00;
      h.length_bytes  = LEN_ONE_BYTE;
    end else begin
      h.length_first  = {r.payload_length[6:0], 1'b0};
      h.length_second = r.payload_length[14:7];
      h.length_bytes  = LEN_TWO_BYTE;
    end
    crc = fcs_step(FCS_INIT, h.address_byte);
    crc = fcs_step(crc, h.control_byte);
    if (!is_uih) begin
      crc = fcs_step(crc, h.length_first);
      if (h.length_bytes == LEN_TWO_BYTE) crc = fcs_step(crc, h.length_second);
    end
    h.fcs = ~crc;
    return h;
  endfunction

  // Random request: full-range fields, with extra weight near the length split
  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    pick                = $urandom_range(99, 0);
    r.frame_kind        = 3'($urandom_range(7, 0));
    r.dlci              = 6'($urandom);
    r.locally_initiated = 1'($urandom);
    if (pick < 40) r.payload_length = 15'($urandom_range(127, 0));
    else if (pick < 50) r.payload_length = pick[0] ? 15'd127 : 15'd128;
    else r.payload_length = 15'($urandom);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%02h expected 0x%02h", name, got, want));
  endtask

  // Driver: offer queued requests, predict each accepted one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hdr_expected.push_back(build_header(in_data));
        if (in_data.payload_length >= SHORT_LEN_LIMIT) two_byte_frames++;
        if (in_data.frame_kind >= KIND_UIH) uih_like_frames++;
      end
      if (!in_valid || in_ready) begin
        if (req_backlog.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= req_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each header beat, then choose next ready
  always @(posedge clk) begin
    hdr_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (hdr_expected.size() == 0) begin
          report_mismatch($sformatf("header beat 0x%h with nothing expected", out_data));
        end else begin
          want = hdr_expected.pop_front();
          check_field("address_byte", out_data.address_byte, want.address_byte);
          check_field("control_byte", out_data.control_byte, want.control_byte);
          check_field("length_first", out_data.length_first, want.length_first);
          check_field("length_second", out_data.length_second, want.length_second);
          check_field("length_bytes", 8'(out_data.length_bytes), 8'(want.length_bytes));
          check_field("fcs", out_data.fcs, want.fcs);
          hdr_checked++;
        end
      end
      // long hold-off lets the pipe fill and back up onto the input
      if (pressure_armed && !stall_done) begin
        stall_done <= 1'b1;
        stall_left <= LONG_STALL;
        out_ready  <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
      end
    end
  end

  // Watchdog on cycles with work outstanding but no beat moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (req_backlog.size() == 0 && !in_valid && hdr_expected.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no progress for %0d cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [14:0] boundary_lengths[10];
    req_t        r;
    boundary_lengths = '{15'd0, 15'd1, 15'd127, 15'd128, 15'd129,
                         15'd255, 15'd256, 15'd16383, 15'd16384, 15'd32767};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: every kind code, both DLCI extremes, both C/R sources, length edges
    for (int i = 0; i < 20; i++) begin
      r.frame_kind        = 3'(i % 8);
      r.dlci              = i[0] ? 6'd63 : 6'((i * 5) % 64);
      r.payload_length    = boundary_lengths[i % 10];
      r.locally_initiated = i[1];
      req_backlog.push_back(r);
    end

    // Three idle profiles; the long receiver hold-off opens the last one
    for (int mode = 0; mode < 3; mode++) begin
      sender_idle_pct   <= (mode == 0) ? 38 : (mode == 1) ? 73 : 0;
      receiver_idle_pct <= (mode == 0) ? 73 : (mode == 1) ? 38 : 0;
      if (mode == 2) pressure_armed <= 1'b1;
      for (int n = 0; n < RANDOM_PER_MODE; n++) req_backlog.push_back(random_request());
      @(posedge clk);
      while (req_backlog.size() != 0 || in_valid || hdr_expected.size() != 0)
        @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d header beats: %0d with a two-byte length, %0d UIH-coded frames,",
             hdr_checked, two_byte_frames, uih_like_frames);
    $display("under three idle profiles plus a %0d-cycle output hold-off.", LONG_STALL);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
